// ===== design/peval_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package peval_pkg;

    // field widths
    localparam int unsigned XW    = 16;   // sample, signed Q4.12
    localparam int unsigned CW    = 16;   // coefficient, signed Q8.8
    localparam int unsigned AW    = 32;   // accumulator, signed Q16.16
    localparam int unsigned DW    = 3;    // degree register
    localparam int unsigned PW    = AW + XW;        // full product width
    localparam int unsigned XFRAC = 12;             // fraction bits of x
    localparam int unsigned CSH   = 8;              // Q8.8 to Q16.16 shift
    localparam int unsigned SW    = PW - XFRAC + 1; // shifted product plus carry

    // coefficient count and highest meaningful degree
    localparam int unsigned NUM_COEF   = 7;
    localparam int unsigned MAX_DEGREE = 6;
    localparam int unsigned NUM_STEPS  = MAX_DEGREE;

    // configuration register indexes
    localparam logic [DW-1:0] REG_DEGREE    = 3'd0;
    localparam logic [DW-1:0] REG_COEF_BASE = 3'd1;

    // what one Horner stage does with the item passing through it
    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,   // coefficient index of the stage lies above the degree, keep accumulator
        MODE_LOAD   = 2'd1,   // coefficient index of the stage equals the degree, seed accumulator
        MODE_HORNER = 2'd2    // coefficient index of the stage lies below the degree, multiply and add
    } t_step_mode;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [DW-1:0]                degree;   // already clamped to MAX_DEGREE
        logic [NUM_COEF-1:0][CW-1:0]  coef;
    } t_cfg;

    // Q8.8 coefficient widened to Q16.16
    function automatic logic signed [AW-1:0] coef_to_acc(input logic [CW-1:0] c);
        logic signed [AW-1:0] w;
        w = AW'(signed'(c));
        return w <<< CSH;
    endfunction

endpackage

`default_nettype wire

// ===== design/peval_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module peval_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [peval_pkg::DW-1:0]    i_cfg_index,
    input  wire logic [peval_pkg::CW-1:0]    i_cfg_data,
    output peval_pkg::t_cfg                  o_cfg
);

    logic [peval_pkg::DW-1:0]                         r_degree;
    logic [peval_pkg::NUM_COEF-1:0][peval_pkg::CW-1:0] r_coef;
    logic [peval_pkg::DW-1:0]                         w_coef_idx;

    assign o_cfg_ready = 1'b1;
    assign w_coef_idx  = i_cfg_index - peval_pkg::REG_COEF_BASE;

    // register writes, every index maps to a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_coef   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == peval_pkg::REG_DEGREE) begin
                r_degree <= i_cfg_data[peval_pkg::DW-1:0];
            end else begin
                r_coef[w_coef_idx] <= i_cfg_data;
            end
        end
    end

    // degree seven has no meaning and acts as the top degree
    always_comb begin
        o_cfg.coef = r_coef;
        if (r_degree > peval_pkg::DW'(peval_pkg::MAX_DEGREE)) begin
            o_cfg.degree = peval_pkg::DW'(peval_pkg::MAX_DEGREE);
        end else begin
            o_cfg.degree = r_degree;
        end
    end

endmodule

`default_nettype wire

// ===== design/peval_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one Horner step in two stages: multiply, then shift, add and saturate
module peval_step (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire peval_pkg::t_step_mode              i_mode,
    input  wire logic [peval_pkg::CW-1:0]           i_coef,
    input  wire logic                               i_valid,
    input  wire logic signed [peval_pkg::AW-1:0]    i_acc,
    input  wire logic                               i_ovf,
    input  wire logic signed [peval_pkg::XW-1:0]    i_x,
    output logic                                    o_valid,
    output logic signed [peval_pkg::AW-1:0]         o_acc,
    output logic                                    o_ovf,
    output logic signed [peval_pkg::XW-1:0]         o_x
);

    localparam logic signed [peval_pkg::SW-1:0] SAT_MAX =
        peval_pkg::SW'({1'b0, {(peval_pkg::AW-1){1'b1}}});
    localparam logic signed [peval_pkg::SW-1:0] SAT_MIN =
        -peval_pkg::SW'({1'b0, {(peval_pkg::AW-1){1'b1}}}) - 1;

    // multiply stage
    logic                                  r_valid_a;
    logic signed [peval_pkg::PW-1:0]       r_prod;
    logic signed [peval_pkg::AW-1:0]       r_acc_a;
    logic                                  r_ovf_a;
    logic signed [peval_pkg::XW-1:0]       r_x_a;
    peval_pkg::t_step_mode                 r_mode_a;
    logic [peval_pkg::CW-1:0]              r_coef_a;

    // add stage
    logic                                  r_valid_b;
    logic signed [peval_pkg::AW-1:0]       r_acc_b;
    logic                                  r_ovf_b;
    logic signed [peval_pkg::XW-1:0]       r_x_b;

    logic signed [peval_pkg::SW-1:0]       w_sum;
    logic signed [peval_pkg::AW-1:0]       n_acc_b;
    logic                                  n_ovf_b;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    // product of accumulator and sample
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= peval_pkg::PW'(i_acc) * peval_pkg::PW'(i_x);
            r_acc_a  <= i_acc;
            r_ovf_a  <= i_ovf;
            r_x_a    <= i_x;
            r_mode_a <= i_mode;
            r_coef_a <= i_coef;
        end
    end

    // floor shift by fraction bits, add widened coef, saturate if Horner
    always_comb begin
        w_sum = peval_pkg::SW'(r_prod >>> peval_pkg::XFRAC)
              + peval_pkg::SW'(peval_pkg::coef_to_acc(r_coef_a));
        case (r_mode_a)
            peval_pkg::MODE_HORNER: begin
                if (w_sum > SAT_MAX) begin
                    n_acc_b = peval_pkg::AW'(SAT_MAX);
                    n_ovf_b = 1'b1;
                end else if (w_sum < SAT_MIN) begin
                    n_acc_b = peval_pkg::AW'(SAT_MIN);
                    n_ovf_b = 1'b1;
                end else begin
                    n_acc_b = peval_pkg::AW'(w_sum);
                    n_ovf_b = r_ovf_a;
                end
            end
            peval_pkg::MODE_LOAD: begin
                n_acc_b = peval_pkg::coef_to_acc(r_coef_a);
                n_ovf_b = 1'b0;
            end
            default: begin
                n_acc_b = r_acc_a;
                n_ovf_b = r_ovf_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc_b <= n_acc_b;
            r_ovf_b <= n_ovf_b;
            r_x_b   <= r_x_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_acc   = r_acc_b;
    assign o_ovf   = r_ovf_b;
    assign o_x     = r_x_b;

endmodule

`default_nettype wire

// ===== design/polynomial_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  accepted when                     payload
// s_axis    in         i_s_axis_tvalid & o_s_axis_tready  tdata[15:0] x_value
// m_axis    out        o_m_axis_tvalid & i_m_axis_tready  tdata[31:0] poly_value,
//                                                        tuser[0] overflow
// cfg       in         i_cfg_valid & o_cfg_ready          index 0 degree, 1..7 coef_0..6
//
// one item per cycle while the result is not stalled; each Horner step has a
// multiplier stage, then a shift, add and saturate stage, over six unrolled steps
// synchronous active-low reset clears valid bits and configuration to zero
// the whole chain advances together; a stalled result holds every stage,
// and the input is taken whenever the result register is empty or being taken
module polynomial_evaluator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire logic [15:0]    i_s_axis_tdata,    // [15:0] x_value
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    output logic [31:0]         o_m_axis_tdata,    // [31:0] poly_value
    output logic                o_m_axis_tuser,    // [0] overflow
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);

    localparam int unsigned NS = peval_pkg::NUM_STEPS;

    peval_pkg::t_cfg                          w_cfg;
    logic                                     w_en;
    peval_pkg::t_step_mode                    w_mode  [NS];
    logic                                     w_valid [NS+1];
    logic signed [peval_pkg::AW-1:0]          w_acc   [NS+1];
    logic                                     w_ovf   [NS+1];
    logic signed [peval_pkg::XW-1:0]          w_x     [NS+1];

    peval_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // global advance: the result register is free or being taken
    assign w_en            = !w_valid[NS] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // chain entry, seeded with the top coefficient
    assign w_valid[0] = i_s_axis_tvalid;
    assign w_acc[0]   = peval_pkg::coef_to_acc(w_cfg.coef[NS]);
    assign w_ovf[0]   = 1'b0;
    assign w_x[0]     = signed'(i_s_axis_tdata);

    // step g handles coefficient index NS-1-g
    always_comb begin
        for (int g = 0; g < NS; g++) begin
            if (w_cfg.degree > peval_pkg::DW'(NS - 1 - g)) begin
                w_mode[g] = peval_pkg::MODE_HORNER;
            end else if (w_cfg.degree == peval_pkg::DW'(NS - 1 - g)) begin
                w_mode[g] = peval_pkg::MODE_LOAD;
            end else begin
                w_mode[g] = peval_pkg::MODE_PASS;
            end
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_step
        peval_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mode  (w_mode[g]),
            .i_coef  (w_cfg.coef[NS-1-g]),
            .i_valid (w_valid[g]),
            .i_acc   (w_acc[g]),
            .i_ovf   (w_ovf[g]),
            .i_x     (w_x[g]),
            .o_valid (w_valid[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_ovf   (w_ovf[g+1]),
            .o_x     (w_x[g+1])
        );
    end

    // last stage register is the result register
    assign o_m_axis_tvalid = w_valid[NS];
    assign o_m_axis_tdata  = w_acc[NS];
    assign o_m_axis_tuser  = w_ovf[NS];

endmodule

`default_nettype wire
